// ----- rtl/ccts_pkg.sv -----
// Shared types and constants for the cycle counter timestamp unit.
// Used by the controller, datapath, divider and top level; no dependencies.
package ccts_pkg;

    // Field widths.
    localparam int unsigned KIND_W     = 3;
    localparam int unsigned COUNT_W    = 32;
    localparam int unsigned CPU_W      = 10;
    localparam int unsigned DIVIDEND_W = 64;
    localparam int unsigned DIVISOR_W  = 30;
    localparam int unsigned USEC_W     = 20;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_TICK  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_START = 3'd2;
    localparam logic [KIND_W-1:0] KIND_STOP  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESET = 3'd4;
    localparam logic [KIND_W-1:0] KIND_INIT  = 3'd5;

    // Conversion constants.
    localparam logic [CPU_W-1:0]     CPU_RESET         = 10'd600;
    localparam logic [USEC_W-1:0]    MICROS_PER_SECOND = 20'd1000000;
    localparam logic [DIVISOR_W-1:0] FREQ_RESET        = 30'd600000000;

    // Input item.
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COUNT_W-1:0] cycle_value;
    } item_t;

    // Result item.
    typedef struct packed {
        logic [63:0]        raw_cycles;
        logic [31:0]        whole_seconds;
        logic [USEC_W-1:0]  micros_in_second;
        logic [63:0]        total_micros;
        logic [63:0]        total_nanos;
    } result_t;

    // Which of the four divisions the shared divider is working on.
    typedef enum logic [1:0] {
        OP_SEC   = 2'd0,
        OP_USEC  = 2'd1,
        OP_TOTUS = 2'd2,
        OP_TOTNS = 2'd3
    } div_op_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load_item;
        logic    zero_result;
        logic    div_start;
        div_op_t div_op;
        logic    capture;
        div_op_t cap_op;
        logic    load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_read;
        logic active;
    } dp_status_t;

endpackage

// ----- rtl/cycle_counter_timestamp_unit.sv -----
// Top level of the cycle counter timestamp unit.
// Depends on ccts_pkg, ccts_ctrl, ccts_dp and ccts_div.
//
// Channel   Signals                          Direction  Carries
// input     in_valid, in_stall, in_data      in         item_t: kind, cycle_value
// output    out_valid, out_stall, out_data   out        result_t: five time fields
// config    cfg_valid, cfg_ready, cfg_data   in         cycles_per_microsecond
//
// Tick, start, stop, reset, init and unused kinds are taken without leaving idle.
// A read while running goes through one setup state, then four
// 64-step divisions on the single shared radix-2 divider, then the output load.
// A read while stopped or not initialized gives an all-zero result without the divider.
// The output register holds one result; a new item is taken while it waits,
// but a finished read waits for the previous result to be transferred.
// Reset restores the CPU_RESET divisor setting and clears all flags.
module cycle_counter_timestamp_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  ccts_pkg::item_t             in_data,
    output logic                        out_valid,
    input  logic                        out_stall,
    output ccts_pkg::result_t           out_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [ccts_pkg::CPU_W-1:0]  cfg_data
);
    import ccts_pkg::*;

    ctrl_cmd_t             cmd;
    dp_status_t            status;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic [DIVIDEND_W-1:0] div_quotient;
    logic [DIVISOR_W-1:0]  div_remainder;

    // The user keeps configuration writes to idle (not enforced); all are taken.
    assign cfg_ready = 1'b1;

    ccts_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .div_done  (div_done),
        .cmd       (cmd)
    );

    ccts_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_data      (cfg_data),
        .in_data       (in_data),
        .cmd           (cmd),
        .status        (status),
        .div_dividend  (div_dividend),
        .div_divisor   (div_divisor),
        .div_quotient  (div_quotient),
        .div_remainder (div_remainder),
        .out_data      (out_data)
    );

    ccts_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .done      (div_done),
        .quotient  (div_quotient),
        .remainder (div_remainder)
    );

endmodule

// ----- rtl/ccts_div.sv -----
// Shared radix-2 restoring divider, one quotient bit per cycle.
// Depends on ccts_pkg for operand widths.
module ccts_div (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [ccts_pkg::DIVIDEND_W-1:0]  dividend,
    input  logic [ccts_pkg::DIVISOR_W-1:0]   divisor,
    output logic                             done,
    output logic [ccts_pkg::DIVIDEND_W-1:0]  quotient,
    output logic [ccts_pkg::DIVISOR_W-1:0]   remainder
);
    import ccts_pkg::*;

    localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DIVIDEND_W - 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [DIVIDEND_W-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_W-1:0]  rem_reg, rem_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;
    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  q_bit;

    // One trial subtraction per cycle; quotient bits shift in at the bottom.
    assign trial = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign q_bit = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        count_next = count_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        dsr_next   = dsr_reg;
        if (start)
        begin
            busy_next  = 1'b1;
            count_next = '0;
            dvd_next   = dividend;
            rem_next   = '0;
            dsr_next   = divisor;
        end
        else if (busy_reg)
        begin
            dvd_next   = {dvd_reg[DIVIDEND_W-2:0], q_bit};
            rem_next   = q_bit ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            count_next = count_reg + 1'b1;
            if (count_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state is reset; operands are not.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            count_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done      = done_reg;
    assign quotient  = dvd_reg;
    assign remainder = rem_reg;

endmodule

// ----- rtl/ccts_dp.sv -----
// Datapath: extension state, divisor setup, divider operands and results.
// Depends on ccts_pkg; driven by commands from ccts_ctrl.
module ccts_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_valid,
    input  logic [ccts_pkg::CPU_W-1:0]       cfg_data,
    input  ccts_pkg::item_t                  in_data,
    input  ccts_pkg::ctrl_cmd_t              cmd,
    output ccts_pkg::dp_status_t             status,
    output logic [ccts_pkg::DIVIDEND_W-1:0]  div_dividend,
    output logic [ccts_pkg::DIVISOR_W-1:0]   div_divisor,
    input  logic [ccts_pkg::DIVIDEND_W-1:0]  div_quotient,
    input  logic [ccts_pkg::DIVISOR_W-1:0]   div_remainder,
    output ccts_pkg::result_t                out_data
);
    import ccts_pkg::*;

    logic [CPU_W-1:0]      cpu_reg;
    logic [DIVISOR_W-1:0]  freq_reg;
    logic [COUNT_W-1:0]    wrap_count_reg, wrap_count_next;
    logic [COUNT_W-1:0]    last_sample_reg, last_sample_next;
    logic                  ready_flag_reg, ready_flag_next;
    logic                  run_flag_reg, run_flag_next;
    logic [DIVIDEND_W-1:0] raw_reg;
    result_t               res_reg;
    result_t               out_reg;
    logic [CPU_W-1:0]      cpu_eff;
    logic [DIVIDEND_W-1:0] nanos;

    // A zero divisor setting is treated as one.
    assign cpu_eff = (cfg_data == '0) ? CPU_W'(1) : cfg_data;

    // Configuration: keep the effective divisor and the clock frequency.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cpu_reg  <= CPU_RESET;
            freq_reg <= FREQ_RESET;
        end
        else if (cfg_valid)
        begin
            cpu_reg  <= cpu_eff;
            freq_reg <= DIVISOR_W'(cpu_eff) * DIVISOR_W'(MICROS_PER_SECOND);
        end
    end

    assign status.is_read = (in_data.kind == KIND_READ);
    assign status.active  = ready_flag_reg & run_flag_reg;

    // Extension state update for each transferred item.
    always_comb
    begin
        wrap_count_next  = wrap_count_reg;
        last_sample_next = last_sample_reg;
        ready_flag_next  = ready_flag_reg;
        run_flag_next    = run_flag_reg;
        if (cmd.load_item)
        begin
            case (in_data.kind)
                KIND_TICK:
                begin
                    if (ready_flag_reg && run_flag_reg)
                    begin
                        if (in_data.cycle_value < last_sample_reg)
                        begin
                            wrap_count_next = wrap_count_reg + 1'b1;
                        end
                        last_sample_next = in_data.cycle_value;
                    end
                end
                KIND_START:
                begin
                    if (ready_flag_reg)
                    begin
                        run_flag_next = 1'b1;
                    end
                end
                KIND_STOP:
                begin
                    if (ready_flag_reg)
                    begin
                        run_flag_next = 1'b0;
                    end
                end
                KIND_RESET:
                begin
                    if (ready_flag_reg)
                    begin
                        wrap_count_next  = '0;
                        last_sample_next = '0;
                    end
                end
                KIND_INIT:
                begin
                    wrap_count_next  = '0;
                    last_sample_next = '0;
                    ready_flag_next  = 1'b1;
                    run_flag_next    = 1'b1;
                end
                default:
                begin
                    wrap_count_next = wrap_count_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_count_reg  <= '0;
            last_sample_reg <= '0;
            ready_flag_reg  <= 1'b0;
            run_flag_reg    <= 1'b0;
        end
        else
        begin
            wrap_count_reg  <= wrap_count_next;
            last_sample_reg <= last_sample_next;
            ready_flag_reg  <= ready_flag_next;
            run_flag_reg    <= run_flag_next;
        end
    end

    // Extended count of each transferred item, taken at transfer; a read uses it.
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            raw_reg <= {wrap_count_reg, in_data.cycle_value};
        end
    end

    // Times 1000 as 1024 - 32 + 8, wrapping modulo 2^64.
    assign nanos = (raw_reg << 10) - (raw_reg << 5) + (raw_reg << 3);

    // Divider operands for the requested division.
    always_comb
    begin
        case (cmd.div_op)
            OP_SEC:
            begin
                div_dividend = raw_reg;
                div_divisor  = freq_reg;
            end
            OP_USEC:
            begin
                div_dividend = DIVIDEND_W'(div_remainder);
                div_divisor  = DIVISOR_W'(cpu_reg);
            end
            OP_TOTUS:
            begin
                div_dividend = raw_reg;
                div_divisor  = DIVISOR_W'(cpu_reg);
            end
            OP_TOTNS:
            begin
                div_dividend = nanos;
                div_divisor  = DIVISOR_W'(cpu_reg);
            end
            default:
            begin
                div_dividend = raw_reg;
                div_divisor  = freq_reg;
            end
        endcase
    end

    // Result collection as each division finishes.
    always_ff @(posedge clk)
    begin
        if (cmd.zero_result)
        begin
            res_reg <= '0;
        end
        else if (cmd.capture)
        begin
            case (cmd.cap_op)
                OP_SEC:
                begin
                    res_reg.raw_cycles    <= raw_reg;
                    res_reg.whole_seconds <= div_quotient[31:0];
                end
                OP_USEC:
                begin
                    res_reg.micros_in_second <= div_quotient[USEC_W-1:0];
                end
                OP_TOTUS:
                begin
                    res_reg.total_micros <= div_quotient;
                end
                OP_TOTNS:
                begin
                    res_reg.total_nanos <= div_quotient;
                end
                default:
                begin
                    res_reg.total_nanos <= div_quotient;
                end
            endcase
        end
    end

    // Output register, loaded when the previous result has been taken.
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign out_data = out_reg;

endmodule

// ----- rtl/ccts_ctrl.sv -----
// Controller: input and output handshakes and the division sequence.
// Depends on ccts_pkg; commands ccts_dp and watches the divider's done.
module ccts_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    output logic                    out_valid,
    input  logic                    out_stall,
    input  ccts_pkg::dp_status_t    status,
    input  logic                    div_done,
    output ccts_pkg::ctrl_cmd_t     cmd
);
    import ccts_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_PREP  = 7'b0000010,
        S_SEC   = 7'b0000100,
        S_USEC  = 7'b0001000,
        S_TOTUS = 7'b0010000,
        S_TOTNS = 7'b0100000,
        S_DONE  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and commands.
    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.div_op  = OP_SEC;
        cmd.cap_op  = OP_SEC;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    if (status.is_read)
                    begin
                        if (status.active)
                        begin
                            state_next = S_PREP;
                        end
                        else
                        begin
                            cmd.zero_result = 1'b1;
                            state_next      = S_DONE;
                        end
                    end
                end
            end
            S_PREP:
            begin
                cmd.div_start = 1'b1;
                cmd.div_op    = OP_SEC;
                state_next    = S_SEC;
            end
            S_SEC:
            begin
                cmd.div_op = OP_USEC;
                if (div_done)
                begin
                    cmd.capture   = 1'b1;
                    cmd.cap_op    = OP_SEC;
                    cmd.div_start = 1'b1;
                    state_next    = S_USEC;
                end
            end
            S_USEC:
            begin
                cmd.div_op = OP_TOTUS;
                if (div_done)
                begin
                    cmd.capture   = 1'b1;
                    cmd.cap_op    = OP_USEC;
                    cmd.div_start = 1'b1;
                    state_next    = S_TOTUS;
                end
            end
            S_TOTUS:
            begin
                cmd.div_op = OP_TOTNS;
                if (div_done)
                begin
                    cmd.capture   = 1'b1;
                    cmd.cap_op    = OP_TOTUS;
                    cmd.div_start = 1'b1;
                    state_next    = S_TOTNS;
                end
            end
            S_TOTNS:
            begin
                if (div_done)
                begin
                    cmd.capture = 1'b1;
                    cmd.cap_op  = OP_TOTNS;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared when the result is transferred.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ----- bench/cycle_counter_timestamp_unit_tb.sv -----
// Self-checking testbench for the cycle counter timestamp unit.
// Needs ccts_pkg and the cycle_counter_timestamp_unit RTL. A built-in timestamp
// predictor computes each read result, and the bench compares every output transfer with it.
module cycle_counter_timestamp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ccts_pkg::*;

    // Kinds that the unit must ignore.
    localparam logic [KIND_W-1:0] KIND_UNUSED_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_UNUSED_B = 3'd7;

    // Long enough to cover any running read still in flight.
    localparam int SETTLE_CYCLES = 400;
    localparam int CYCLE_LIMIT   = 1500000;
    localparam int PHASE_ITEMS   = 150;
    localparam int MAX_REPORTS   = 10;

    logic    clk       = 1'b0;
    logic    rst_n     = 1'b0;
    logic    in_valid  = 1'b0;
    logic    in_stall;
    item_t   in_data   = '0;
    logic    out_valid;
    logic    out_stall = 1'b0;
    result_t out_data;
    logic    cfg_valid = 1'b0;
    logic    cfg_ready;
    logic [CPU_W-1:0] cfg_data = '0;

    // Predictor state: the unit's flags, its 64-bit extension and its divisor setting.
    logic [COUNT_W-1:0] wraps        = '0;
    logic [COUNT_W-1:0] prev_sample  = '0;
    logic               unit_ready   = 1'b0;
    logic               unit_running = 1'b0;
    logic [CPU_W-1:0]   cpu_setting  = CPU_RESET;

    item_t   item_backlog[$];
    result_t pending_readouts[$];
    result_t want_readout;
    logic [COUNT_W-1:0] gen_last = '0;
    logic pace_on = 1'b1;
    int   send_gap = 0;
    int   hold_left = 0;
    int   mismatch_count = 0;
    int   cycle_count = 0;

    cycle_counter_timestamp_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Update the predicted unit state for one accepted item; a read queues its result.
    task automatic advance_timestamp_model(input item_t it);
        result_t     r;
        logic [63:0] divisor;
        logic [63:0] freq;
        logic [63:0] raw;
        case (it.kind)
            KIND_TICK:
                if (unit_ready && unit_running)
                begin
                    if (it.cycle_value < prev_sample)
                        wraps = wraps + 32'd1;
                    prev_sample = it.cycle_value;
                end
            KIND_READ:
            begin
                r = '0;
                if (unit_ready && unit_running)
                begin
                    // A zero setting divides by one.
                    divisor = (cpu_setting == '0) ? 64'd1 : 64'(cpu_setting);
                    freq = divisor * 64'd1000000;
                    raw = {wraps, it.cycle_value};
                    r.raw_cycles       = raw;
                    r.whole_seconds    = 32'(raw / freq);
                    r.micros_in_second = 20'((raw % freq) / divisor);
                    r.total_micros     = raw / divisor;
                    r.total_nanos      = (raw * 64'd1000) / divisor;
                end
                pending_readouts.push_back(r);
            end
            KIND_START:
                if (unit_ready)
                    unit_running = 1'b1;
            KIND_STOP:
                if (unit_ready)
                    unit_running = 1'b0;
            KIND_RESET:
                if (unit_ready)
                begin
                    wraps = '0;
                    prev_sample = '0;
                end
            KIND_INIT:
            begin
                wraps = '0;
                prev_sample = '0;
                unit_ready = 1'b1;
                unit_running = 1'b1;
            end
            default: ;
        endcase
    endtask

    // Input driver: predict each transfer, then present the next item after its gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                advance_timestamp_model(in_data);
            if (!in_valid || !in_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap = send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (item_backlog.size() != 0)
                begin
                    in_data <= item_backlog.pop_front();
                    in_valid <= 1'b1;
                    send_gap = pace_on ? $urandom_range(0, 19) : 0;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output monitor: check each transfer against the oldest prediction, then stall at random.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_readouts.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result raw=%h", out_data.raw_cycles);
                end
                else
                begin
                    want_readout = pending_readouts.pop_front();
                    if (out_data.raw_cycles !== want_readout.raw_cycles
                        || out_data.whole_seconds !== want_readout.whole_seconds
                        || out_data.micros_in_second !== want_readout.micros_in_second
                        || out_data.total_micros !== want_readout.total_micros
                        || out_data.total_nanos !== want_readout.total_nanos)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS)
                        begin
                            $display("mismatch expected raw=%h sec=%0d usec=%0d us=%0d ns=%0d",
                                     want_readout.raw_cycles, want_readout.whole_seconds,
                                     want_readout.micros_in_second,
                                     want_readout.total_micros, want_readout.total_nanos);
                            $display("         actual   raw=%h sec=%0d usec=%0d us=%0d ns=%0d",
                                     out_data.raw_cycles, out_data.whole_seconds,
                                     out_data.micros_in_second,
                                     out_data.total_micros, out_data.total_nanos);
                        end
                    end
                end
                hold_left = pace_on ? $urandom_range(0, 19) : 0;
            end
            else if (hold_left > 0)
                hold_left = hold_left - 1;
            out_stall <= (hold_left != 0);
        end
    end

    task automatic push_item(input logic [KIND_W-1:0] k, input logic [COUNT_W-1:0] v);
        item_t it;
        it.kind = k;
        it.cycle_value = v;
        item_backlog.push_back(it);
    endtask

    // Mostly running sessions of ticks and reads on a rising count that wraps often,
    // with flag changes, restarts and some noise mixed in.
    task automatic push_random_item();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            case ($urandom_range(0, 9))
                0, 1: gen_last = $urandom;
                2: ;
                default: gen_last = gen_last + $urandom_range(0, 32'h7FFF_FFFF);
            endcase
            push_item(KIND_TICK, gen_last);
        end
        else if (pick < 75)
            push_item(KIND_READ, ($urandom_range(0, 3) == 0) ? $urandom
                                                              : gen_last + $urandom_range(0, 1000));
        else if (pick < 80)
            push_item(KIND_START, $urandom);
        else if (pick < 84)
            push_item(KIND_STOP, $urandom);
        else if (pick < 87)
            push_item(KIND_RESET, $urandom);
        else if (pick < 90)
            push_item(KIND_INIT, $urandom);
        else if (pick < 95)
            push_item(KIND_W'($urandom_range(0, 7)), $urandom);
        else
            push_item(($urandom_range(0, 1) == 0) ? KIND_UNUSED_A : KIND_UNUSED_B, $urandom);
    endtask

    // Hold off until every queued item is sent and every result has come back.
    task automatic drain_unit();
        while (item_backlog.size() != 0 || in_valid || pending_readouts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cpu_setting(input logic [CPU_W-1:0] v);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        cpu_setting = v;
    endtask

    // Run limit.
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    // Stimulus sequence and verdict.
    initial
    begin
        logic [CPU_W-1:0] settings[7];
        settings = '{10'd1, 10'd1000, 10'd0, 10'd1023, 10'd600, 10'd1, 10'd0};
        settings[4] = CPU_W'($urandom_range(2, 999));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed pass at the reset setting: ignored kinds and flags, zero reads,
        // wrap detection, stop and restart, and extension clearing.
        push_item(KIND_READ, 32'hFFFF_FFFF);
        push_item(KIND_START, 32'h0);
        push_item(KIND_READ, 32'h1);
        push_item(KIND_TICK, 32'hFFFF_FFFF);
        push_item(KIND_RESET, 32'h0);
        push_item(KIND_STOP, 32'h0);
        push_item(KIND_UNUSED_A, 32'h0);
        push_item(KIND_UNUSED_B, 32'hFFFF_FFFF);
        push_item(KIND_INIT, 32'h0);
        push_item(KIND_READ, 32'h0);
        push_item(KIND_READ, 32'hFFFF_FFFF);
        push_item(KIND_TICK, 32'hFFFF_FFF0);
        push_item(KIND_TICK, 32'hFFFF_FFF0);
        push_item(KIND_TICK, 32'h5);
        push_item(KIND_READ, 32'hFFFF_FFFF);
        push_item(KIND_STOP, 32'h0);
        push_item(KIND_READ, 32'h7);
        push_item(KIND_TICK, 32'h0);
        push_item(KIND_START, 32'h0);
        push_item(KIND_READ, 32'd123456789);
        push_item(KIND_RESET, 32'h0);
        push_item(KIND_READ, 32'hFFFF_FFFF);
        push_item(KIND_INIT, 32'h0);
        push_item(KIND_READ, 32'd42);
        drain_unit();

        // Random phases, each after a divisor write of its own; two of them run without idling.
        for (int p = 0; p < 7; p++)
        begin
            write_cpu_setting(settings[p]);
            pace_on = (p != 2 && p != 5);
            push_item(KIND_INIT, $urandom);
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_item();
            drain_unit();
        end

        mismatch_count += pending_readouts.size();
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
